// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, clocked and held off during reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

// ===== src/g711_pkg.sv =====
// Shared types, constants and companding functions of the G.711 codec.
`default_nettype none

package g711_pkg;

    localparam int PCM_W   = 16;
    localparam int CODE_W  = 8;
    localparam int TDATA_W = 24;

    // Register indexes on the configuration port
    localparam logic REG_LAW_SELECT = 1'b0;
    localparam logic REG_DIRECTION  = 1'b1;

    localparam logic LAW_MU = 1'b0;
    localparam logic LAW_A  = 1'b1;

    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    localparam logic [14:0] MU_BIAS       = 15'h0084;
    localparam logic [15:0] MU_BIAS16     = 16'h0084;
    localparam logic [16:0] MU_CLIP       = 17'd32767;
    localparam logic [15:0] MU_CLIP16     = 16'h7FFF;
    localparam logic [7:0]  MU_POS_MASK   = 8'hFF;
    localparam logic [7:0]  MU_NEG_MASK   = 8'h7F;
    localparam logic [7:0]  ALAW_XOR      = 8'h55;
    localparam logic [7:0]  ALAW_POS_MASK = 8'hD5;
    localparam logic [7:0]  ALAW_NEG_MASK = 8'h55;
    localparam logic [7:0]  ALAW_OVF_CODE = 8'h7F;
    localparam logic [14:0] ALAW_SEG_OFS  = 15'h0108;

    localparam logic signed [16:0] ALAW_SEG_TOP [8] = '{
        17'sh000FF, 17'sh001FF, 17'sh003FF, 17'sh007FF,
        17'sh00FFF, 17'sh01FFF, 17'sh03FFF, 17'sh07FFF
    };

    typedef struct packed {
        logic law_sel;
        logic dir;
    } cfg_t;

    function automatic logic [15:0] mulaw_decode(input logic [7:0] code);
        logic [7:0]  u;
        logic [14:0] mag;
        logic [15:0] r;
        u   = ~code;
        mag = (15'({u[3:0], 3'b000}) + MU_BIAS) << u[6:4];
        if (u[7])
            r = MU_BIAS16 - {1'b0, mag};
        else
            r = {1'b0, mag} - MU_BIAS16;
        return r;
    endfunction

    function automatic logic [15:0] alaw_decode(input logic [7:0] code);
        logic [7:0]  a;
        logic [14:0] t;
        logic [15:0] r;
        a = code ^ ALAW_XOR;
        t = 15'({a[3:0], 4'b0000});
        if (a[6:4] == 3'd0)
            t = t + 15'd8;
        else
            t = (t + ALAW_SEG_OFS) << (a[6:4] - 3'd1);
        if (a[7])
            r = {1'b0, t};
        else
            r = 16'd0 - {1'b0, t};
        return r;
    endfunction

    function automatic logic [7:0] alaw_encode(input logic [15:0] x);
        logic signed [16:0] v;
        logic [7:0]         mask;
        logic [2:0]         seg;
        logic [3:0]         q;
        logic               ovf;
        logic [7:0]         r;
        if (!x[15])
        begin
            mask = ALAW_POS_MASK;
            v    = $signed({x[15], x});
        end
        else
        begin
            mask = ALAW_NEG_MASK;
            // -1..-7 land negative here; their quantization bits read as all ones
            v    = -$signed({x[15], x}) - 17'sd8;
        end
        ovf = 1'b1;
        seg = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v <= ALAW_SEG_TOP[i])
            begin
                seg = 3'(i);
                ovf = 1'b0;
            end
        end
        case (seg) inside
            3'd0, 3'd1: q = v[7:4];
            3'd2:       q = v[8:5];
            3'd3:       q = v[9:6];
            3'd4:       q = v[10:7];
            3'd5:       q = v[11:8];
            3'd6:       q = v[12:9];
            default:    q = v[13:10];
        endcase
        if (ovf)
            r = ALAW_OVF_CODE ^ mask;
        else
            r = {1'b0, seg, q} ^ mask;
        return r;
    endfunction

    function automatic logic [7:0] mulaw_encode(input logic [15:0] x);
        logic [15:0] absx;
        logic [16:0] mag17;
        logic [15:0] mag;
        logic [2:0]  s;
        logic [7:0]  smask;
        absx  = x[15] ? (16'd0 - x) : x;
        smask = x[15] ? MU_NEG_MASK : MU_POS_MASK;
        mag17 = {1'b0, absx} + {2'b00, MU_BIAS};
        mag   = (mag17 > MU_CLIP) ? MU_CLIP16 : mag17[15:0];
        s     = 3'd0;
        if ((mag & 16'h7800) != 16'd0)
            s = 3'd4;
        else
            mag = mag << 4;
        if ((mag & 16'h6000) != 16'd0)
            s = s + 3'd2;
        else
            mag = mag << 2;
        if (mag[14])
            s = s + 3'd1;
        else
            mag = mag << 1;
        return {1'b0, s, mag[13:10]} ^ smask;
    endfunction

endpackage

`default_nettype wire

// ===== src/g711_conv.sv =====
// Combinational G.711 conversion for one sample, both laws and directions.
`default_nettype none

module g711_conv (
    input  wire g711_pkg::cfg_t                cfg,
    input  wire logic [g711_pkg::PCM_W-1:0]    pcm_in,
    input  wire logic [g711_pkg::CODE_W-1:0]   code_in,
    output logic      [g711_pkg::PCM_W-1:0]    pcm_out,
    output logic      [g711_pkg::CODE_W-1:0]   code_out
);

    logic [g711_pkg::PCM_W-1:0]  dec_mu;
    logic [g711_pkg::PCM_W-1:0]  dec_a;
    logic [g711_pkg::CODE_W-1:0] enc_mu;
    logic [g711_pkg::CODE_W-1:0] enc_a;

    always_comb
    begin
        dec_mu = g711_pkg::mulaw_decode(code_in);
        dec_a  = g711_pkg::alaw_decode(code_in);
        enc_mu = g711_pkg::mulaw_encode(pcm_in);
        enc_a  = g711_pkg::alaw_encode(pcm_in);
    end

    // The unused side of the result is held at zero
    always_comb
    begin
        pcm_out  = '0;
        code_out = '0;
        if (cfg.dir == g711_pkg::DIR_ENCODE)
            code_out = (cfg.law_sel == g711_pkg::LAW_A) ? enc_a : enc_mu;
        else
            pcm_out  = (cfg.law_sel == g711_pkg::LAW_A) ? dec_a : dec_mu;
    end

endmodule

`default_nettype wire

// ===== src/g711_alaw_ulaw_codec.sv =====
// Top level of the G.711 mu-law / A-law codec: input stage, converter, output stage.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+------------------------------------------
//   s_axis    | tvalid / tready         | tdata: pcm_in[15:0], code_in[23:16]; tlast
//   m_axis    | tvalid / tready         | tdata: pcm_out[15:0], code_out[23:16]; tlast
//   cfg       | cfg_we                  | cfg_index (0 law_select, 1 direction), cfg_data
//
// One sample per clock sustained while the output is not stalled; a beat passes the input and output registers.
// The conversion sits between the input register and the output register.
// Reset clears both valid flags and the configuration (mu-law, decode).
// An output stall holds the result; the input stage keeps accepting until it also fills.
`default_nettype none

module g711_alaw_ulaw_codec (
    input  wire  logic                           clk,
    input  wire  logic                           rst_n,
    input  wire  logic                           s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  logic [g711_pkg::TDATA_W-1:0]   s_axis_tdata,  // pcm_in[15:0], code_in[23:16]
    input  wire  logic                           s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire  logic                           m_axis_tready,
    output logic       [g711_pkg::TDATA_W-1:0]   m_axis_tdata,  // pcm_out[15:0], code_out[23:16]
    output logic                                 m_axis_tlast,
    input  wire  logic                           cfg_we,
    input  wire  logic                           cfg_index,
    input  wire  logic                           cfg_data
);

    g711_pkg::cfg_t                cfg_reg;
    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [g711_pkg::PCM_W-1:0]    in_pcm_reg;
    logic [g711_pkg::CODE_W-1:0]   in_code_reg;
    logic                          in_last_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [g711_pkg::PCM_W-1:0]    out_pcm_reg;
    logic [g711_pkg::CODE_W-1:0]   out_code_reg;
    logic                          out_last_reg;
    logic                          in_beat;
    logic                          out_load;
    logic [g711_pkg::PCM_W-1:0]    conv_pcm;
    logic [g711_pkg::CODE_W-1:0]   conv_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.law_sel <= g711_pkg::LAW_MU;
            cfg_reg.dir     <= g711_pkg::DIR_DECODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                g711_pkg::REG_LAW_SELECT: cfg_reg.law_sel <= cfg_data;
                g711_pkg::REG_DIRECTION:  cfg_reg.dir     <= cfg_data;
                default:                  cfg_reg         <= cfg_reg;
            endcase
        end
    end

    assign out_load       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || out_load;
    assign in_beat        = s_axis_tvalid && s_axis_tready;
    assign in_valid_next  = in_beat || (in_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            in_pcm_reg  <= s_axis_tdata[g711_pkg::PCM_W-1:0];
            in_code_reg <= s_axis_tdata[g711_pkg::PCM_W +: g711_pkg::CODE_W];
            in_last_reg <= s_axis_tlast;
        end
        if (out_load)
        begin
            out_pcm_reg  <= conv_pcm;
            out_code_reg <= conv_code;
            out_last_reg <= in_last_reg;
        end
    end

    g711_conv u_conv (
        .cfg      (cfg_reg),
        .pcm_in   (in_pcm_reg),
        .code_in  (in_code_reg),
        .pcm_out  (conv_pcm),
        .code_out (conv_code)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_code_reg, out_pcm_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== src/g711_chk.sv =====
// Port-level checker for the G.711 codec, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module g711_chk (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_axis_tvalid,
    input wire logic                         s_axis_tready,
    input wire logic [g711_pkg::TDATA_W-1:0] s_axis_tdata,
    input wire logic                         s_axis_tlast,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [g711_pkg::TDATA_W-1:0] m_axis_tdata,
    input wire logic                         m_axis_tlast
);

    // A stalled output beat keeps its payload
    `ASSERT_PROP(a_out_hold, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "output beat changed while stalled")

    // Input only backs up when the output register is full and stalled
    `ASSERT_NEVER(a_ready_low, clk, rst_n, !s_axis_tready && !(m_axis_tvalid && !m_axis_tready), "input stalled with output free")

    // An accepted beat passes the input register and reaches the output register when the sink is ready
    `ASSERT_PROP(a_latency, clk, rst_n, (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid, "accepted beat did not reach output")

    // The input payload is not used by the checks; it is watched for unknowns on a beat
    `ASSERT_NEVER(a_in_known, clk, rst_n, s_axis_tvalid && s_axis_tready && $isunknown({s_axis_tdata, s_axis_tlast}), "unknown bits in an accepted input beat")

endmodule

bind g711_alaw_ulaw_codec g711_chk u_g711_chk (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the G.711 mu-law / A-law codec.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] pcm;
        logic [7:0]  code;
        logic        last;
    } sample_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [g711_pkg::TDATA_W-1:0]  s_axis_tdata = '0;  // pcm_in[15:0], code_in[23:16]
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [g711_pkg::TDATA_W-1:0]  m_axis_tdata;       // pcm_out[15:0], code_out[23:16]
    logic                          m_axis_tlast;
    logic                          cfg_we = 1'b0;
    logic                          cfg_index = 1'b0;
    logic                          cfg_data = 1'b0;

    // Configuration as the predictor sees it
    logic    cur_law = g711_pkg::LAW_MU;
    logic    cur_dir = g711_pkg::DIR_DECODE;
    sample_t pending_results[$];
    int      mismatches = 0;
    bit      src_burst = 1'b0;
    bit      snk_burst = 1'b0;

    g711_alaw_ulaw_codec u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [15:0] mu_expand(input logic [7:0] code);
        logic [7:0] u;
        int         mag;
        u   = ~code;
        mag = ((int'(u[3:0]) << 3) + 132) << u[6:4];
        return u[7] ? 16'(132 - mag) : 16'(mag - 132);
    endfunction

    function automatic logic [15:0] a_expand(input logic [7:0] code);
        logic [7:0] a;
        int         t;
        a = code ^ 8'h55;
        t = int'(a[3:0]) << 4;
        if (a[6:4] == 3'd0)
            t = t + 8;
        else
            t = (t + 'h108) << (int'(a[6:4]) - 1);
        return a[7] ? 16'(t) : 16'(-t);
    endfunction

    function automatic logic [7:0] mu_compress(input logic signed [15:0] x);
        int         mag;
        int         seg;
        logic [7:0] sign_mask;
        if (x < 0)
        begin
            mag       = 132 - int'(x);
            sign_mask = 8'h7F;
        end
        else
        begin
            mag       = 132 + int'(x);
            sign_mask = 8'hFF;
        end
        if (mag > 32767)
            mag = 32767;
        seg = 0;
        if ((mag & 'h7800) != 0)
            seg = 4;
        else
            mag = mag << 4;
        if ((mag & 'h6000) != 0)
            seg = seg + 2;
        else
            mag = mag << 2;
        if ((mag & 'h4000) != 0)
            seg = seg + 1;
        else
            mag = mag << 1;
        return 8'((seg << 4) | ((mag & 'h3C00) >> 10)) ^ sign_mask;
    endfunction

    function automatic logic [7:0] a_compress(input logic signed [15:0] x);
        int          v;
        int          seg;
        logic [7:0]  mask;
        logic [31:0] vbits;
        logic [3:0]  q;
        if (x >= 0)
        begin
            mask = 8'hD5;
            v    = int'(x);
        end
        else
        begin
            mask = 8'h55;
            v    = -int'(x) - 8;
        end
        seg = 8;
        for (int i = 0; i < 8; i++)
            if (seg == 8 && v <= ((256 << i) - 1))
                seg = i;
        if (seg == 8)
            return 8'h7F ^ mask;
        // -1..-7 give a negative v here, so the sign-filled bits yield 15
        vbits = v;
        if (seg < 2)
            q = vbits[7:4];
        else
            q = 4'(vbits >> (seg + 3));
        return 8'((seg << 4) | q) ^ mask;
    endfunction

    function automatic sample_t companded_result(input logic [15:0] pcm,
                                                 input logic [7:0] code,
                                                 input logic last);
        sample_t r;
        r.pcm  = '0;
        r.code = '0;
        r.last = last;
        if (cur_dir == g711_pkg::DIR_ENCODE)
            r.code = (cur_law == g711_pkg::LAW_A) ? a_compress(pcm) : mu_compress(pcm);
        else
            r.pcm = (cur_law == g711_pkg::LAW_A) ? a_expand(code) : mu_expand(code);
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_sample(input logic [15:0] pcm, input logic [7:0] code,
                               input logic last);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {code, pcm};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(companded_result(pcm, code, last));
    endtask

    // Lower valid and let every outstanding beat come back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == g711_pkg::REG_LAW_SELECT)
            cur_law = val;
        else
            cur_dir = val;
    endtask

    task automatic set_mode(input logic law, input logic dir);
        drain();
        write_reg(g711_pkg::REG_LAW_SELECT, law);
        write_reg(g711_pkg::REG_DIRECTION, dir);
    endtask

    function automatic logic [15:0] rand_pcm;
        logic [15:0] r;
        case ($urandom_range(0, 3))
            0: r = 16'($urandom);
            1: r = 16'($urandom_range(0, 15));
            2: r = 16'($urandom) >> $urandom_range(0, 15);
            default:
                case ($urandom_range(0, 2))
                    0:       r = 16'h8000;
                    1:       r = 16'h7FFF;
                    default: r = 16'(32635 + $urandom_range(0, 2));
                endcase
        endcase
        if ($urandom_range(0, 1))
            r = -r;
        return r;
    endfunction

    // ---------------------------------------------------------------- sink side

    initial
    begin : sink
        int stall;
        wait (rst_n);
        forever
        begin
            stall = snk_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        sample_t exp_s;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat tdata=%h tlast=%b",
                             $realtime, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                exp_s = pending_results.pop_front();
                if (m_axis_tdata[15:0] !== exp_s.pcm || m_axis_tdata[23:16] !== exp_s.code
                    || m_axis_tlast !== exp_s.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: pcm %h/%h code %h/%h last %b/%b (exp/act)",
                                 $realtime, exp_s.pcm, m_axis_tdata[15:0],
                                 exp_s.code, m_axis_tdata[23:16],
                                 exp_s.last, m_axis_tlast);
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_mu_decode;
        set_mode(g711_pkg::LAW_MU, g711_pkg::DIR_DECODE);
        send_sample(16'h1234, 8'h00, 1'b0);
        send_sample(16'hFFFF, 8'h7F, 1'b0);
        send_sample(16'h0000, 8'h80, 1'b1);
        send_sample(16'h8000, 8'hFF, 1'b1);
    endtask

    task automatic test_a_decode;
        set_mode(g711_pkg::LAW_A, g711_pkg::DIR_DECODE);
        send_sample(16'h0000, 8'h55, 1'b0);   // segment 0, negative
        send_sample(16'hFFFF, 8'hD5, 1'b0);   // segment 0, positive
        send_sample(16'h5A5A, 8'h00, 1'b0);
        send_sample(16'hA5A5, 8'hFF, 1'b1);
    endtask

    task automatic test_mu_encode;
        set_mode(g711_pkg::LAW_MU, g711_pkg::DIR_ENCODE);
        send_sample(16'h8000, 8'hFF, 1'b0);
        send_sample(16'h7FFF, 8'h00, 1'b0);
        send_sample(16'h0000, 8'hAA, 1'b0);
        send_sample(16'hFFFF, 8'h55, 1'b1);
        send_sample(16'd32635, 8'h0F, 1'b0);  // biased value exactly at clip
        send_sample(16'd32636, 8'hF0, 1'b1);  // one above clip
    endtask

    task automatic test_a_encode;
        set_mode(g711_pkg::LAW_A, g711_pkg::DIR_ENCODE);
        send_sample(16'h8000, 8'h00, 1'b0);
        send_sample(16'h7FFF, 8'hFF, 1'b0);
        send_sample(16'h0000, 8'h12, 1'b0);
        send_sample(16'hFFFF, 8'h34, 1'b0);   // small negatives: quant bits all ones
        send_sample(16'hFFF9, 8'h56, 1'b0);
        send_sample(16'hFFF8, 8'h78, 1'b0);
        send_sample(16'hFFF7, 8'h9A, 1'b1);
    endtask

    task automatic test_random_traffic;
        logic law;
        logic dir;
        for (int p = 0; p < 8; p++)
        begin
            if (p < 4)
            begin
                law = p[0];
                dir = p[1];
            end
            else
            begin
                law = $urandom_range(0, 1);
                dir = $urandom_range(0, 1);
            end
            set_mode(law, dir);
            src_burst = (p == 2 || p == 5);
            snk_burst = (p == 3 || p == 5);
            for (int n = 0; n < 82; n++)
                send_sample(rand_pcm(), 8'($urandom_range(0, 255)),
                            $urandom_range(0, 7) == 0);
        end
        src_burst = 1'b0;
        snk_burst = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_mu_decode();
        test_a_decode();
        test_mu_encode();
        test_a_encode();
        test_random_traffic();
        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
